@@ sv/rhp_pkg.sv @@
// types, constants and the serial type length table shared by the record header parser
`default_nettype none

package rhp_pkg;

   // default limits
   localparam int MAX_FIELDS_DEF       = 128;
   localparam int MAX_RECORD_BYTES_DEF = 65536;

   // varint accumulator and serial type widths
   localparam int VALUE_W = 18;
   localparam int LEN_W   = 17;

   // serial type codes with special meaning
   localparam logic [VALUE_W-1:0] TYPE_RESERVED_A = 18'd10;
   localparam logic [VALUE_W-1:0] TYPE_RESERVED_B = 18'd11;
   localparam logic [VALUE_W-1:0] TYPE_VAR_BASE   = 18'd12;

   // varint byte that takes all eight bits
   localparam logic [3:0] VARINT_FULL_BYTE = 4'd8;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;

   // result queue
   localparam int RES_DEPTH = 4;

   // result kind and status codes
   localparam logic KIND_DESC      = 1'b0;
   localparam logic KIND_STATUS    = 1'b1;
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CORRUPT = 1'b1;

   typedef enum logic [1:0] {
      PH_HDR_SIZE = 2'd0,
      PH_TYPES    = 2'd1,
      PH_BODY     = 2'd2
   } rhp_phase_type;

   typedef struct packed {
      logic        kind;
      logic [6:0]  index;
      logic [17:0] code;
      logic [15:0] offset;
      logic [15:0] length;
      logic [7:0]  count;
      logic        status;
      logic        last;
   } rhp_res_type;

   // body length of the fixed-size serial types
   function automatic logic [LEN_W-1:0] fixed_len(input logic [3:0] code);
      logic [LEN_W-1:0] len;
      case (code)
         4'd1:    len = 17'd1;
         4'd2:    len = 17'd2;
         4'd3:    len = 17'd3;
         4'd4:    len = 17'd4;
         4'd5:    len = 17'd6;
         4'd6:    len = 17'd8;
         4'd7:    len = 17'd8;
         default: len = 17'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ sv/record_header_parser_unit.sv @@
// record header parser: byte stream in, field descriptors and record status out
`default_nettype none

// channel   dir  handshake                data                               user / last
// req_      in   req_tvalid/req_tready    [7:0] data byte                     tlast last byte
// rsp_      out  rsp_tvalid/rsp_tready    index,code,offset,length,count,st   tuser kind, tlast
//
// one record byte is taken per cycle while req_tready is high, the parse update is a single registered step
// a byte yields up to two result items (descriptor, then status on the last byte)
// results go through a four-entry queue; req_tready drops while three or more wait
// a stalled result side only holds the queue, the parser state does not move
// synchronous reset clears the parser state and the queue pointers, no clearing pass
// after the last byte the parser is back at its reset state for the next record

module record_header_parser_unit #(
   parameter int MAX_FIELDS       = rhp_pkg::MAX_FIELDS_DEF,
   parameter int MAX_RECORD_BYTES = rhp_pkg::MAX_RECORD_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rhp_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] data_byte
   input  wire logic                            req_tlast,  // last_byte
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [6:0] field_index, [24:7] type_code, [40:25] field_offset, [56:41] field_length,
   // [64:57] field_count, [65] status, [71:66] zero
   output logic [rhp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser,  // result_kind
   output logic                                 rsp_tlast   // last
);

   import rhp_pkg::*;

   // counter widths follow the limits
   localparam int CNT_W     = $clog2(MAX_RECORD_BYTES + 1);
   localparam int FLD_W     = $clog2(MAX_FIELDS + 1);
   localparam int WIDE_W    = ((CNT_W > VALUE_W) ? CNT_W : VALUE_W) + 1;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
   localparam logic [WIDE_W-1:0] MAX_REC_W = WIDE_W'(MAX_RECORD_BYTES);

   // parser state
   rhp_phase_type        phase_ff, phase_in, phase_step;
   logic [VALUE_W-1:0]   varint_value_ff, varint_value_in;
   logic                 varint_ovf_ff, varint_ovf_in;
   logic [3:0]           varint_bytes_ff, varint_bytes_in;
   logic [CNT_W-1:0]     byte_count_ff, byte_count_in, byte_count_step;
   logic [CNT_W-1:0]     header_size_ff, header_size_in, header_size_step;
   logic [CNT_W-1:0]     body_offset_ff, body_offset_in, body_offset_step;
   logic [FLD_W-1:0]     fields_seen_ff, fields_seen_in, fields_step;
   logic                 corrupt_ff, corrupt_in, corrupt_step;

   // result queue
   rhp_res_type          res_mem_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RES_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RES_CNT_W-1:0] fifo_count_ff, fifo_count_in;

   // per-byte decode
   logic                 accept, pop;
   logic [7:0]           data_byte;
   logic [WIDE_W-1:0]    pos1_w;
   logic                 len_limit, corrupt_pre, active;
   logic                 nine, done, ovf_new;
   logic [VALUE_W-1:0]   v_new;
   logic [WIDE_W-1:0]    v_w;
   logic                 hs_bad, type_bad, fields_full, body_over, header_end;
   logic [LEN_W-1:0]     type_len;
   logic [VALUE_W-1:0]   var_len_raw;
   logic [WIDE_W-1:0]    end_w;
   logic                 set_corrupt, take_hs, have_desc, rec_ok;
   logic                 push0, push1;
   rhp_res_type          desc_res, stat_res, slot0;

   assign accept    = req_tvalid & req_tready;
   assign pop       = rsp_tvalid & rsp_tready;
   assign data_byte = req_tdata[7:0];

   // position of this byte, counted from one
   assign pos1_w      = WIDE_W'(byte_count_ff) + WIDE_W'(1);
   assign len_limit   = byte_count_ff >= CNT_W'(MAX_RECORD_BYTES);
   assign corrupt_pre = corrupt_ff | len_limit;
   assign active      = !corrupt_pre && (phase_ff != PH_BODY);

   // varint accumulate: seven bits a byte, the ninth byte gives eight
   assign nine = varint_bytes_ff >= VARINT_FULL_BYTE;
   always_comb begin
      if (nine) begin
         ovf_new = varint_ovf_ff | (varint_value_ff[VALUE_W-1:VALUE_W-8] != 8'd0);
         v_new   = {varint_value_ff[VALUE_W-9:0], data_byte};
         done    = 1'b1;
      end else begin
         ovf_new = varint_ovf_ff | (varint_value_ff[VALUE_W-1:VALUE_W-7] != 7'd0);
         v_new   = {varint_value_ff[VALUE_W-8:0], data_byte[6:0]};
         done    = !data_byte[7];
      end
   end
   assign v_w = WIDE_W'(v_new);

   // header size and serial type checks
   assign hs_bad      = ovf_new || (v_w > MAX_REC_W) || (v_w < pos1_w);
   assign type_bad    = ovf_new || (v_new == TYPE_RESERVED_A) || (v_new == TYPE_RESERVED_B);
   assign fields_full = fields_seen_ff >= FLD_W'(MAX_FIELDS);
   assign var_len_raw = v_new - TYPE_VAR_BASE;
   assign type_len    = (v_new < TYPE_RESERVED_A) ? fixed_len(v_new[3:0])
                                                  : var_len_raw[VALUE_W-1:1];
   assign end_w       = WIDE_W'(body_offset_ff) + WIDE_W'(type_len);
   assign body_over   = end_w > MAX_REC_W;
   assign header_end  = pos1_w == WIDE_W'(header_size_ff);

   // what this byte does
   always_comb begin
      set_corrupt = 1'b0;
      take_hs     = 1'b0;
      have_desc   = 1'b0;
      if (active) begin
         if (!done) begin
            // type varint still open at the end of the header
            set_corrupt = (phase_ff == PH_TYPES) && (pos1_w >= WIDE_W'(header_size_ff));
         end else if (phase_ff == PH_HDR_SIZE) begin
            set_corrupt = hs_bad;
            take_hs     = !hs_bad;
         end else begin
            set_corrupt = type_bad || fields_full || body_over;
            have_desc   = !(type_bad || fields_full || body_over);
         end
      end
   end

   // phase next state
   always_comb begin
      phase_step = phase_ff;
      if (take_hs) begin
         phase_step = (v_w == pos1_w) ? PH_BODY : PH_TYPES;
      end else if (have_desc && header_end) begin
         phase_step = PH_BODY;
      end
      if (accept && req_tlast) begin
         phase_in = PH_HDR_SIZE;
      end else if (accept) begin
         phase_in = phase_step;
      end else begin
         phase_in = phase_ff;
      end
   end

   // datapath next state
   always_comb begin
      corrupt_step     = corrupt_pre | set_corrupt;
      byte_count_step  = len_limit ? byte_count_ff : byte_count_ff + CNT_W'(1);
      header_size_step = take_hs ? CNT_W'(v_new) : header_size_ff;
      body_offset_step = take_hs   ? CNT_W'(v_new) :
                         have_desc ? CNT_W'(end_w) : body_offset_ff;
      fields_step      = have_desc ? fields_seen_ff + FLD_W'(1) : fields_seen_ff;

      varint_value_in  = varint_value_ff;
      varint_ovf_in    = varint_ovf_ff;
      varint_bytes_in  = varint_bytes_ff;
      corrupt_in       = corrupt_ff;
      byte_count_in    = byte_count_ff;
      header_size_in   = header_size_ff;
      body_offset_in   = body_offset_ff;
      fields_seen_in   = fields_seen_ff;

      if (accept && req_tlast) begin
         // record done, back to reset state
         varint_value_in = '0;
         varint_ovf_in   = 1'b0;
         varint_bytes_in = '0;
         corrupt_in      = 1'b0;
         byte_count_in   = '0;
         header_size_in  = '0;
         body_offset_in  = '0;
         fields_seen_in  = '0;
      end else if (accept) begin
         if (active) begin
            varint_value_in = done ? '0 : v_new;
            varint_ovf_in   = done ? 1'b0 : ovf_new;
            varint_bytes_in = done ? '0 : varint_bytes_ff + 4'd1;
         end
         corrupt_in      = corrupt_step;
         byte_count_in   = byte_count_step;
         header_size_in  = header_size_step;
         body_offset_in  = body_offset_step;
         fields_seen_in  = fields_step;
      end
   end

   // record is well formed when the body ends exactly at the last byte
   assign rec_ok = !corrupt_step && (phase_step == PH_BODY)
                   && (WIDE_W'(body_offset_step) == pos1_w);

   // result items
   always_comb begin
      desc_res        = '0;
      desc_res.kind   = KIND_DESC;
      desc_res.index  = 7'(fields_seen_ff);
      desc_res.code   = v_new;
      desc_res.offset = 16'(body_offset_ff);
      desc_res.length = 16'(type_len);
      desc_res.last   = !req_tlast;

      stat_res        = '0;
      stat_res.kind   = KIND_STATUS;
      stat_res.count  = 8'(fields_step);
      stat_res.status = rec_ok ? STATUS_OK : STATUS_CORRUPT;
      stat_res.last   = 1'b1;

      slot0 = have_desc ? desc_res : stat_res;
   end

   assign push0 = accept & (have_desc | req_tlast);
   assign push1 = accept & have_desc & req_tlast;

   // queue pointers
   assign wr_ptr_in     = wr_ptr_ff + RES_PTR_W'(push0) + RES_PTR_W'(push1);
   assign rd_ptr_in     = rd_ptr_ff + RES_PTR_W'(pop);
   assign fifo_count_in = fifo_count_ff + RES_CNT_W'(push0) + RES_CNT_W'(push1)
                          - RES_CNT_W'(pop);

   // room for two results before taking a byte
   assign req_tready = fifo_count_ff <= RES_CNT_W'(RES_DEPTH - 2);
   assign rsp_tvalid = fifo_count_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR_SIZE;
         varint_value_ff <= '0;
         varint_ovf_ff   <= 1'b0;
         varint_bytes_ff <= '0;
         byte_count_ff   <= '0;
         header_size_ff  <= '0;
         body_offset_ff  <= '0;
         fields_seen_ff  <= '0;
         corrupt_ff      <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fifo_count_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         varint_value_ff <= varint_value_in;
         varint_ovf_ff   <= varint_ovf_in;
         varint_bytes_ff <= varint_bytes_in;
         byte_count_ff   <= byte_count_in;
         header_size_ff  <= header_size_in;
         body_offset_ff  <= body_offset_in;
         fields_seen_ff  <= fields_seen_in;
         corrupt_ff      <= corrupt_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         fifo_count_ff   <= fifo_count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (push0) begin
         res_mem_ff[wr_ptr_ff] <= slot0;
      end
      if (push1) begin
         res_mem_ff[wr_ptr_ff + RES_PTR_W'(1)] <= stat_res;
      end
   end

   // output packing
   assign rsp_tdata = {6'd0,
                       res_mem_ff[rd_ptr_ff].status,
                       res_mem_ff[rd_ptr_ff].count,
                       res_mem_ff[rd_ptr_ff].length,
                       res_mem_ff[rd_ptr_ff].offset,
                       res_mem_ff[rd_ptr_ff].code,
                       res_mem_ff[rd_ptr_ff].index};
   assign rsp_tuser = res_mem_ff[rd_ptr_ff].kind;
   assign rsp_tlast = res_mem_ff[rd_ptr_ff].last;

`ifndef ASSERT_OFF
   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= RES_CNT_W'(RES_DEPTH))
      else $error("result queue overflow");

   // a status item always closes the results of its byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_STATUS)) |-> rsp_tlast)
      else $error("status item without last");

   // descriptors carry no count and no status
   a_desc_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_DESC)) |-> (rsp_tdata[65:57] == 9'd0))
      else $error("descriptor with status bits");

   // the last byte returns the parser to its reset state
   a_record_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> ((phase_ff == PH_HDR_SIZE) && (byte_count_ff == '0)
                                 && !corrupt_ff && (fields_seen_ff == '0)))
      else $error("parser not restarted after last byte");
`endif

endmodule

`default_nettype wire

@@ tb/record_header_parser_unit_tb.sv @@
// self-checking testbench for the record header parser: record byte stream in, descriptors and status items out
`timescale 1ns / 100ps

module record_header_parser_unit_tb;
   import rhp_pkg::*;

   localparam int FIELD_LIMIT  = MAX_FIELDS_DEF;
   localparam int RECORD_LIMIT = MAX_RECORD_BYTES_DEF;
   localparam int RANDOM_BYTES = 120;
   localparam int LONG_HOLD    = 200;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 3000000;

   // ways of damaging an otherwise well-formed record
   typedef enum int unsigned {
      SPOIL_TRUNCATE,
      SPOIL_EXTEND,
      SPOIL_OVERWRITE,
      SPOIL_BAD_CODE,
      SPOIL_NOISE,
      SPOIL_BIG_VARINT
   } spoil_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [6:0] field_index, [24:7] type_code, [40:25] field_offset, [56:41] field_length,
   // [64:57] field_count, [65] status, [71:66] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;   // result_kind
   logic                  rsp_tlast;   // last

   // body length of the fixed-size serial types 0..9
   int unsigned fixed_body_len [10] = '{0, 1, 2, 3, 4, 6, 8, 8, 0, 0};

   // shadow parser state
   rhp_phase_type ph;
   logic [VALUE_W-1:0] vi_value;
   logic          vi_ovf;
   int unsigned   vi_count;
   int unsigned   rec_pos;
   int unsigned   hdr_size;
   int unsigned   body_off;
   int unsigned   n_fields;
   logic          rec_bad;

   rhp_res_type   due_results[$];   // descriptors and status items still to come out
   rhp_res_type   res_want;
   logic [7:0]    rec_buf[$];       // record being built for sending

   int unsigned   err_count    = 0;
   int unsigned   results_seen = 0;
   int unsigned   bytes_sent   = 0;
   int unsigned   cycle_count  = 0;
   int unsigned   hold_asks    = 0;
   int unsigned   holds_taken  = 0;
   int unsigned   rsp_stall_left = 0;
   bit            req_idle_en  = 1'b1;
   bit            rsp_idle_en  = 1'b1;

   record_header_parser_unit #(
      .MAX_FIELDS      (FIELD_LIMIT),
      .MAX_RECORD_BYTES(RECORD_LIMIT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly short idle stretches, now and then a long one
   function automatic int unsigned idle_span();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: random stalls, plus a long hold whenever a test asks for one
   always @(posedge clock) begin
      if (hold_asks != holds_taken) begin
         holds_taken++;
         rsp_stall_left = LONG_HOLD;
      end else if (rsp_stall_left == 0 && rsp_idle_en && $urandom_range(0, 99) < 25) begin
         rsp_stall_left = idle_span();
      end
      if (rsp_stall_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int unsigned serial_body_len(input int unsigned code);
      if (code < 10) return fixed_body_len[code];
      return (code - TYPE_VAR_BASE) / 2;
   endfunction

   function automatic void clear_parser();
      ph       = PH_HDR_SIZE;
      vi_value = '0;
      vi_ovf   = 1'b0;
      vi_count = 0;
      rec_pos  = 0;
      hdr_size = 0;
      body_off = 0;
      n_fields = 0;
      rec_bad  = 1'b0;
   endfunction

   // one record byte through the shadow parser; expected items go to due_results
   function automatic void parse_record_byte(input logic [7:0] b, input logic lst);
      int unsigned pos;
      int unsigned fld_len;
      bit          done;
      bit          ok;
      logic [VALUE_W-1:0] code;
      rhp_res_type desc;
      rhp_res_type stat;
      pos  = rec_pos;
      desc = '0;
      done = 1'b0;
      // byte past the size limit poisons the record, the position stops counting
      if (pos >= RECORD_LIMIT) rec_bad = 1'b1;
      else rec_pos = pos + 1;
      if (!rec_bad && ph != PH_BODY) begin
         if (vi_count >= VARINT_FULL_BYTE) begin
            // ninth varint byte carries all eight bits
            if ((vi_value >> (VALUE_W - 8)) != 0) vi_ovf = 1'b1;
            vi_value = {vi_value[VALUE_W-9:0], b};
            done = 1'b1;
         end else begin
            if ((vi_value >> (VALUE_W - 7)) != 0) vi_ovf = 1'b1;
            vi_value = {vi_value[VALUE_W-8:0], b[6:0]};
            done = !b[7];
         end
         vi_count++;
         if (!done) begin
            // serial type still open at the header's last byte
            if (ph == PH_TYPES && pos + 1 >= hdr_size) rec_bad = 1'b1;
         end else if (ph == PH_HDR_SIZE) begin
            if (vi_ovf || vi_value > RECORD_LIMIT || vi_value < pos + 1) begin
               rec_bad = 1'b1;
            end else begin
               hdr_size = 32'(vi_value);
               body_off = 32'(vi_value);
               ph = (vi_value == pos + 1) ? PH_BODY : PH_TYPES;
            end
         end else begin
            code = vi_value;
            if (vi_ovf || code == TYPE_RESERVED_A || code == TYPE_RESERVED_B) begin
               rec_bad = 1'b1;
            end else if (n_fields >= FIELD_LIMIT) begin
               rec_bad = 1'b1;
            end else begin
               fld_len = serial_body_len(32'(code));
               if (body_off + fld_len > RECORD_LIMIT) begin
                  rec_bad = 1'b1;
               end else begin
                  desc.kind   = KIND_DESC;
                  desc.index  = n_fields[6:0];
                  desc.code   = code;
                  desc.offset = body_off[15:0];
                  desc.length = fld_len[15:0];
                  desc.last   = !lst;
                  due_results.push_back(desc);
                  body_off += fld_len;
                  n_fields++;
                  if (pos + 1 == hdr_size) ph = PH_BODY;
               end
            end
         end
         if (done) begin
            vi_value = '0;
            vi_ovf   = 1'b0;
            vi_count = 0;
         end
      end
      if (lst) begin
         ok = !rec_bad && ph == PH_BODY && body_off == pos + 1;
         stat = '0;
         stat.kind   = KIND_STATUS;
         stat.count  = n_fields[7:0];
         stat.status = ok ? STATUS_OK : STATUS_CORRUPT;
         stat.last   = 1'b1;
         due_results.push_back(stat);
         clear_parser();
      end
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      err_count++;
      $display("mismatch in %s: got %0d, expected %0d (result item %0d)",
               what, got, want, results_seen);
   endtask

   task automatic check_field(input string what, input longint unsigned got,
                              input longint unsigned want);
      if (got != want) flag_mismatch(what, got, want);
   endtask

   // result side checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            flag_mismatch("unexpected result item", 1, 0);
         end else begin
            res_want = due_results.pop_front();
            check_field("result_kind",  rsp_tuser,         res_want.kind);
            check_field("field_index",  rsp_tdata[6:0],    res_want.index);
            check_field("type_code",    rsp_tdata[24:7],   res_want.code);
            check_field("field_offset", rsp_tdata[40:25],  res_want.offset);
            check_field("field_length", rsp_tdata[56:41],  res_want.length);
            check_field("field_count",  rsp_tdata[64:57],  res_want.count);
            check_field("status",       rsp_tdata[65],     res_want.status);
            check_field("tdata padding", rsp_tdata[71:66], 0);
            check_field("last",         rsp_tlast,         res_want.last);
         end
         results_seen++;
      end
   end

   // offer one byte, optionally after an idle stretch, and wait for it to be taken
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int unsigned gap;
      gap = (req_idle_en && $urandom_range(0, 99) < 30) ? idle_span() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      parse_record_byte(b, lst);
      bytes_sent++;
   endtask

   task automatic send_record();
      foreach (rec_buf[i]) send_byte(rec_buf[i], i == rec_buf.size() - 1);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // big-endian 7-bit groups, optionally led by redundant zero groups
   function automatic void put_varint(input int unsigned v, input int unsigned pad);
      logic [6:0] grp[$];
      int unsigned rest;
      rest = v;
      do begin
         grp.push_front(rest[6:0]);
         rest = rest >> 7;
      end while (rest != 0);
      repeat (pad) grp.push_front(7'd0);
      foreach (grp[i]) rec_buf.push_back({(i + 1 < grp.size()) ? 1'b1 : 1'b0, grp[i]});
   endfunction

   // nine-byte form: eight continued groups, then a full byte
   function automatic void put_nine(input int unsigned v);
      logic [14:0] val;
      val = v[14:0];
      repeat (7) rec_buf.push_back(8'h80);
      rec_buf.push_back({1'b1, val[14:8]});
      rec_buf.push_back(val[7:0]);
   endfunction

   function automatic int unsigned pick_type(input bit plain);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (plain || sel < 55) return $urandom_range(0, 9);
      if (sel < 97) return TYPE_VAR_BASE + $urandom_range(0, 41);
      return TYPE_VAR_BASE + $urandom_range(0, 200);
   endfunction

   // well-formed record: header size, serial types, then a body of matching length
   function automatic void make_record(input int unsigned nfld, input bit odd, input bit plain);
      logic [7:0]  tq[$];
      int unsigned code;
      int unsigned body_len;
      int unsigned hs;
      int unsigned pad;
      rec_buf.delete();
      body_len = 0;
      repeat (nfld) begin
         code = pick_type(plain);
         body_len += serial_body_len(code);
         if (odd && $urandom_range(0, 9) == 0) put_nine(code);
         else put_varint(code, odd ? $urandom_range(0, 2) : 0);
      end
      tq = rec_buf;
      rec_buf.delete();
      pad = odd ? $urandom_range(0, 2) : 0;
      // the header size counts its own varint
      hs = tq.size() + 1 + pad;
      if (hs >= 128) hs++;
      put_varint(hs, pad);
      foreach (tq[i]) rec_buf.push_back(tq[i]);
      repeat (body_len) rec_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void spoil_record();
      spoil_kind_type how;
      int unsigned    cut;
      how = spoil_kind_type'($urandom_range(0, 5));
      case (how)
         SPOIL_TRUNCATE: if (rec_buf.size() > 1) begin
            cut = $urandom_range(1, rec_buf.size() - 1);
            repeat (cut) rec_buf.delete(rec_buf.size() - 1);
         end
         SPOIL_EXTEND: repeat ($urandom_range(1, 3))
            rec_buf.push_back(8'($urandom_range(0, 255)));
         SPOIL_OVERWRITE: rec_buf[$urandom_range(0, rec_buf.size() - 1)] =
            8'($urandom_range(0, 255));
         SPOIL_BAD_CODE: if (rec_buf.size() > 1) begin
            rec_buf[$urandom_range(1, rec_buf.size() - 1)] =
               $urandom_range(0, 1) ? TYPE_RESERVED_A[7:0] : TYPE_RESERVED_B[7:0];
         end
         SPOIL_NOISE: begin
            rec_buf.delete();
            repeat ($urandom_range(1, 12)) rec_buf.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            // header size over the limit or overflowing, or a huge serial type
            rec_buf.delete();
            if ($urandom_range(0, 1)) begin
               put_varint($urandom_range(RECORD_LIMIT + 1, (1 << 21) - 1), 0);
            end else begin
               put_varint(4, 0);
               put_varint($urandom_range(131070, (1 << 21) - 1), 0);
            end
            repeat ($urandom_range(1, 6)) rec_buf.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic test_directed();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      // empty record, header size only
      rec_buf = '{8'h01};
      send_record();
      // descriptor and status out of the same byte
      rec_buf = '{8'h02, 8'h00};
      send_record();
      // int8 plus empty blob, all-ones body byte
      rec_buf = '{8'h03, 8'h01, 8'h0C, 8'hFF};
      send_record();
      // reserved code after a good field, error sticks to the end
      rec_buf = '{8'h03, 8'h01, TYPE_RESERVED_B[7:0], 8'h55, 8'h00};
      send_record();
      // header size smaller than its own varint
      rec_buf = '{8'h00};
      send_record();
      // header size over the record limit
      rec_buf = '{8'h84, 8'h80, 8'h01, 8'h00};
      send_record();
      // serial type varint running past the header end
      rec_buf = '{8'h02, 8'h81, 8'h00};
      send_record();
      // last byte inside the header
      rec_buf = '{8'h03, 8'h01};
      send_record();
      // body shorter than the types promise
      rec_buf = '{8'h02, 8'h01};
      send_record();
   endtask

   task automatic test_field_limits();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      // one field past the limit: all fields up to the limit are described, then corrupt
      rec_buf.delete();
      put_varint(FIELD_LIMIT + 3, 0);
      repeat (FIELD_LIMIT + 1) rec_buf.push_back($urandom_range(0, 1) ? 8'h00 : 8'h09);
      send_record();
      // largest code: body would end past the record limit
      rec_buf = '{8'h04, 8'h88, 8'h80, 8'h0B, 8'h00};
      send_record();
      // nine-byte serial types, one with the top bit of the full byte set
      rec_buf.delete();
      put_varint(10, 0);
      put_nine(TYPE_VAR_BASE + 1);
      send_record();
      rec_buf.delete();
      put_varint(10, 0);
      put_nine(129);
      repeat (serial_body_len(129)) rec_buf.push_back(8'($urandom_range(0, 255)));
      send_record();
   endtask

   // result side held off while bytes keep coming, then the sender waits for everything
   task automatic test_backpressure();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      hold_asks++;
      repeat (4) begin
         make_record($urandom_range(3, 6), 1'b0, 1'b1);
         send_record();
      end
      wait_results_drained();
      rsp_idle_en = 1'b1;
   endtask

   task automatic test_random_records();
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         req_idle_en = $urandom_range(0, 3) != 0;
         rsp_idle_en = $urandom_range(0, 3) != 0;
         make_record(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6),
                     $urandom_range(0, 3) == 0, 1'b0);
         if ($urandom_range(0, 99) < 30) spoil_record();
         send_record();
      end
   endtask

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      reset      <= 1'b1;
      clear_parser();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_field_limits();
      test_backpressure();
      test_random_records();

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/rhp_pkg.sv
sv/record_header_parser_unit.sv
tb/record_header_parser_unit_tb.sv
